### rtl/core/kmqm_pkg.sv
package kmqm_pkg;

    localparam int MAX_KEYS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int KEY_W    = 16;
    localparam int NUMBER_W = 32;
    localparam int HANDLE_W = 16;
    localparam int ENTRY_W  = NUMBER_W + HANDLE_W;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_PUSH   = 3'd2,
        OP_PEEK   = 3'd3,
        OP_POP    = 3'd4,
        OP_QUERY  = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_EXISTS     = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_META,
        S_EXEC,
        S_PEEK
    } state_t;

endpackage

### rtl/core/keyed_multi_queue_manager.sv
// One command at a time: start is ignored while busy and is taken again in the cycle
// done pulses. The key scan reads one slot key per cycle from the key RAM.
// done is high for one cycle and result ports stay held; the receiver cannot stall.
// Reset (rst_n, async, active low) clears all slots and the sequencer; no clearing pass.
module keyed_multi_queue_manager
    import kmqm_pkg::*;
#(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          opcode,
    input  logic [KEY_W-1:0]    key_id,
    input  logic [NUMBER_W-1:0] entry_number,
    input  logic [HANDLE_W-1:0] entry_handle,
    output logic                done,
    output logic [2:0]          status,
    output logic [NUMBER_W-1:0] front_number,
    output logic [HANDLE_W-1:0] front_handle,
    output logic                not_empty
);

    localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int POS_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int META_W = POS_W + CNT_W;
    localparam int EDEPTH = MAX_KEYS * QUEUE_DEPTH;
    localparam int EA_W   = $clog2(EDEPTH);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_KEYS - 1);
    localparam logic [CNT_W-1:0] QD_CNT   = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] QD_SUM   = SUM_W'(QUEUE_DEPTH);
    localparam logic [POS_W:0]   QD_POS   = (POS_W + 1)'(QUEUE_DEPTH);
    localparam logic [EA_W-1:0]  QD_ADDR  = EA_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    logic [2:0]          op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [NUMBER_W-1:0] num_reg, num_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    logic [MAX_KEYS-1:0] valid_reg, valid_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [NUMBER_W-1:0] fnum_reg, fnum_next;
    logic [HANDLE_W-1:0] fhnd_reg, fhnd_next;
    logic                ne_reg, ne_next;

    // RAM ports
    logic                key_we;
    logic [IDX_W-1:0]    key_addr;
    logic [KEY_W-1:0]    key_rdata;
    logic                meta_we;
    logic [IDX_W-1:0]    meta_addr;
    logic [META_W-1:0]   meta_wdata, meta_rdata;
    logic                ent_we;
    logic [EA_W-1:0]     ent_addr;
    logic [ENTRY_W-1:0]  ent_wdata, ent_rdata;

    logic [POS_W-1:0]    head;
    logic [CNT_W-1:0]    count;
    logic [SUM_W-1:0]    tail_sum;
    logic [POS_W-1:0]    tail_pos;
    logic [POS_W:0]      head_inc;
    logic [POS_W-1:0]    head_adv;
    logic [CNT_W-1:0]    count_dec;
    logic [EA_W-1:0]     slot_base;

    kmqm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_ram
    (
        .clk   (clk),
        .we    (key_we),
        .addr  (key_addr),
        .wdata (key_reg),
        .rdata (key_rdata)
    );

    kmqm_ram #(.WIDTH(META_W), .DEPTH(MAX_KEYS)) u_meta_ram
    (
        .clk   (clk),
        .we    (meta_we),
        .addr  (meta_addr),
        .wdata (meta_wdata),
        .rdata (meta_rdata)
    );

    kmqm_ram #(.WIDTH(ENTRY_W), .DEPTH(EDEPTH)) u_entry_ram
    (
        .clk   (clk),
        .we    (ent_we),
        .addr  (ent_addr),
        .wdata (ent_wdata),
        .rdata (ent_rdata)
    );

    assign head      = meta_rdata[META_W-1:CNT_W];
    assign count     = meta_rdata[CNT_W-1:0];
    assign tail_sum  = SUM_W'(head) + SUM_W'(count);
    assign tail_pos  = (tail_sum >= QD_SUM) ? POS_W'(tail_sum - QD_SUM) : POS_W'(tail_sum);
    assign head_inc  = (POS_W + 1)'(head) + (POS_W + 1)'(1);
    assign head_adv  = (head_inc == QD_POS) ? '0 : POS_W'(head_inc);
    assign count_dec = count - CNT_W'(1);
    assign slot_base = EA_W'(slot_reg) * QD_ADDR;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST:
            begin
                state_next = S_META;
            end
            S_META:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (opcode_t'(op_reg) == OP_PEEK && hit_reg && count != '0)
                begin
                    state_next = S_PEEK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PEEK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        num_next        = num_reg;
        hnd_next        = hnd_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = idx_reg;
        cmp_vld_next    = (state_reg == S_SCAN);
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        fnum_next       = fnum_reg;
        fhnd_next       = fhnd_reg;
        ne_next         = ne_reg;

        key_we     = 1'b0;
        key_addr   = (state_reg == S_SCAN) ? idx_reg : free_slot_reg;
        meta_we    = 1'b0;
        meta_addr  = slot_reg;
        meta_wdata = {head, count};
        ent_we     = 1'b0;
        ent_addr   = slot_base + EA_W'(head);
        ent_wdata  = {num_reg, hnd_reg};

        // compare stage acts on each key RAM read in the cycle after it
        if (cmp_vld_reg)
        begin
            if (valid_reg[cmp_idx_reg] && key_rdata == key_reg && !hit_reg)
            begin
                hit_next  = 1'b1;
                slot_next = cmp_idx_reg;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_slot_next  = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode;
                    key_next        = key_id;
                    num_next        = entry_number;
                    hnd_next        = entry_handle;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_SCAN_LAST, S_META:
            begin
            end
            S_EXEC:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                fnum_next   = '0;
                fhnd_next   = '0;
                ne_next     = hit_reg && count != '0;
                unique case (opcode_t'(op_reg))
                    OP_ADD:
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_EXISTS;
                        end
                        else if (!free_found_reg)
                        begin
                            status_next = ST_TABLE_FULL;
                        end
                        else
                        begin
                            valid_next[free_slot_reg] = 1'b1;
                            key_we     = 1'b1;
                            meta_we    = 1'b1;
                            meta_addr  = free_slot_reg;
                            meta_wdata = '0;
                            ne_next    = 1'b0;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            valid_next[slot_reg] = 1'b0;
                            ne_next = 1'b0;
                        end
                    end
                    OP_PUSH:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (count == QD_CNT)
                        begin
                            status_next = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            ent_we     = 1'b1;
                            ent_addr   = slot_base + EA_W'(tail_pos);
                            meta_we    = 1'b1;
                            meta_wdata = {head, count + CNT_W'(1)};
                            ne_next    = 1'b1;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (count == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // front word comes out of the entry RAM next cycle
                            done_next = 1'b0;
                        end
                    end
                    OP_POP:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else if (count == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            meta_we    = 1'b1;
                            meta_wdata = {head_adv, count_dec};
                            ne_next    = count_dec != '0;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PEEK:
            begin
                done_next = 1'b1;
                fnum_next = ent_rdata[ENTRY_W-1:HANDLE_W];
                fhnd_next = ent_rdata[HANDLE_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        num_reg        <= num_next;
        hnd_reg        <= hnd_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        status_reg     <= status_next;
        fnum_reg       <= fnum_next;
        fhnd_reg       <= fhnd_next;
        ne_reg         <= ne_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign front_number = fnum_reg;
    assign front_handle = fhnd_reg;
    assign not_empty    = ne_reg;

    // done only follows the execute or peek step
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_PEEK))
        else $error("done without execute step");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but not busy");

    a_missing_key_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_NOT_FOUND) |-> !not_empty)
        else $error("missing key reports entries");

    a_front_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && opcode_t'(op_reg) != OP_PEEK) |-> (front_number == '0 && front_handle == '0))
        else $error("front word set outside peek");

endmodule

### rtl/core/kmqm_ram.sv
module kmqm_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### test/tb_keyed_multi_queue_manager.sv
module tb_keyed_multi_queue_manager;
    import kmqm_pkg::*;

    localparam int SLOTS     = MAX_KEYS_DEF;
    localparam int DEPTH     = QUEUE_DEPTH_DEF;
    localparam int HEAD_W    = $clog2(DEPTH);
    localparam int POOL_SIZE = 12;

    // opcodes the block does not define; they must report ok, change nothing and give not_empty
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [2:0]          status;
        logic [NUMBER_W-1:0] number;
        logic [HANDLE_W-1:0] handle;
        logic                not_empty;
    } response_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [2:0]          opcode;
    logic [KEY_W-1:0]    key_id;
    logic [NUMBER_W-1:0] entry_number;
    logic [HANDLE_W-1:0] entry_handle;
    logic                done;
    logic [2:0]          status;
    logic [NUMBER_W-1:0] front_number;
    logic [HANDLE_W-1:0] front_handle;
    logic                not_empty;

    keyed_multi_queue_manager #(
        .MAX_KEYS    (SLOTS),
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key_id       (key_id),
        .entry_number (entry_number),
        .entry_handle (entry_handle),
        .done         (done),
        .status       (status),
        .front_number (front_number),
        .front_handle (front_handle),
        .not_empty    (not_empty)
    );

    // shadow copy of the key table and queue store
    logic                slot_used    [SLOTS];
    logic [KEY_W-1:0]    slot_id      [SLOTS];
    logic [HEAD_W-1:0]   q_head       [SLOTS];
    logic [HEAD_W:0]     q_len        [SLOTS];
    logic [NUMBER_W-1:0] store_number [SLOTS*DEPTH];
    logic [HANDLE_W-1:0] store_handle [SLOTS*DEPTH];

    response_t        pending_responses[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               status_seen [8];
    int               mismatches;
    int               words_sent;
    int               responses_checked;
    bit               idle_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic int slot_of(logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_id[i] == key)
                return i;
        return -1;
    endfunction

    function automatic response_t apply_command(logic [2:0] op, logic [KEY_W-1:0] key,
                                                logic [NUMBER_W-1:0] num,
                                                logic [HANDLE_W-1:0] hnd);
        response_t r;
        int        s;
        int        f;
        int        pos;
        r        = '0;
        r.status = ST_OK;
        s        = slot_of(key);
        case (op)
            OP_ADD:
            begin
                if (s >= 0)
                    r.status = ST_EXISTS;
                else
                begin
                    f = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_used[i])
                            f = i;
                    if (f < 0)
                        r.status = ST_TABLE_FULL;
                    else
                    begin
                        slot_used[f] = 1'b1;
                        slot_id[f]   = key;
                        q_head[f]    = '0;
                        q_len[f]     = '0;
                        s            = f;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (s < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    slot_used[s] = 1'b0;
                    q_head[s]    = '0;
                    q_len[s]     = '0;
                    s            = -1;
                end
            end
            OP_PUSH:
            begin
                if (s < 0)
                    r.status = ST_NOT_FOUND;
                else if (q_len[s] >= DEPTH)
                    r.status = ST_QUEUE_FULL;
                else
                begin
                    pos = s * DEPTH + (int'(q_head[s]) + int'(q_len[s])) % DEPTH;
                    store_number[pos] = num;
                    store_handle[pos] = hnd;
                    q_len[s]          = q_len[s] + 1'b1;
                end
            end
            OP_PEEK, OP_POP:
            begin
                if (s < 0)
                    r.status = ST_NOT_FOUND;
                else if (q_len[s] == 0)
                    r.status = ST_EMPTY;
                else if (op == OP_PEEK)
                begin
                    pos      = s * DEPTH + int'(q_head[s]);
                    r.number = store_number[pos];
                    r.handle = store_handle[pos];
                end
                else
                begin
                    q_head[s] = HEAD_W'((int'(q_head[s]) + 1) % DEPTH);
                    q_len[s]  = q_len[s] - 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (s < 0)
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        r.not_empty = (s >= 0) && (q_len[s] != 0);
        status_seen[r.status]++;
        return r;
    endfunction

    // one word per call; an optional idle burst goes before it
    task automatic send_word(logic [2:0] op, logic [KEY_W-1:0] key,
                             logic [NUMBER_W-1:0] num, logic [HANDLE_W-1:0] hnd);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        key_id       <= key;
        entry_number <= num;
        entry_handle <= hnd;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_responses.push_back(apply_command(op, key, num, hnd));
        words_sent++;
    endtask

    task automatic report_field(string field, logic [NUMBER_W-1:0] want,
                                logic [NUMBER_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        response_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d",
                         $time, status);
                mismatches++;
            end
            else
            begin
                want = pending_responses.pop_front();
                responses_checked++;
                report_field("status", want.status, status);
                report_field("front_number", want.number, front_number);
                report_field("front_handle", want.handle, front_handle);
                report_field("not_empty", want.not_empty, not_empty);
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        // mostly known keys so that adds collide and the table fills
        if ($urandom_range(0, 9) == 0)
            return KEY_W'($urandom());
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [2:0] pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 15)
            return OP_ADD;
        if (w < 23)
            return OP_REMOVE;
        if (w < 53)
            return OP_PUSH;
        if (w < 68)
            return OP_PEEK;
        if (w < 88)
            return OP_POP;
        if (w < 96)
            return OP_QUERY;
        return (w < 98) ? OP_UNUSED_6 : OP_UNUSED_7;
    endfunction

    task automatic test_directed();
        send_word(OP_QUERY, 16'h1234, 32'h0, 16'h0);
        send_word(OP_PEEK, 16'h1234, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_ADD, 16'h0000, 32'h0, 16'h0);
        send_word(OP_ADD, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_ADD, 16'h0000, 32'h0, 16'h0);
        send_word(OP_PEEK, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_POP, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_PUSH, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_PEEK, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_UNUSED_6, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_POP, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_PEEK, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_QUERY, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_UNUSED_7, 16'h1234, 32'h0, 16'h0);
        send_word(OP_REMOVE, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_REMOVE, 16'hFFFF, 32'h0, 16'h0);
        send_word(OP_PUSH, 16'hFFFF, 32'h5A5A_A5A5, 16'hA5A5);
    endtask

    task automatic test_table_full();
        // key 0 already holds a slot, so the last add in the loop is refused
        for (int i = 1; i <= SLOTS; i++)
            send_word(OP_ADD, key_pool[i], $urandom(), HANDLE_W'($urandom()));
        send_word(OP_REMOVE, key_pool[3], $urandom(), HANDLE_W'($urandom()));
        send_word(OP_ADD, key_pool[SLOTS + 1], $urandom(), HANDLE_W'($urandom()));
        send_word(OP_QUERY, key_pool[SLOTS + 1], $urandom(), HANDLE_W'($urandom()));
    endtask

    task automatic test_random_mix(int count);
        repeat (count)
            send_word(pick_op(), pick_key(), $urandom(), HANDLE_W'($urandom()));
    endtask

    // add a key, overfill or partly fill its queue, then drain with peeks and pops
    task automatic test_fill_drain(int rounds);
        logic [KEY_W-1:0] key;
        int               n;
        int               victim;
        repeat (rounds)
        begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (slot_of(key) < 0)
            begin
                victim = $urandom_range(0, SLOTS - 1);
                if (slot_used[victim] && $urandom_range(0, 3) != 0)
                    send_word(OP_REMOVE, slot_id[victim], $urandom(), HANDLE_W'($urandom()));
                send_word(OP_ADD, key, $urandom(), HANDLE_W'($urandom()));
            end
            n = $urandom_range(6, DEPTH + 3);
            repeat (n)
                send_word(OP_PUSH, key, $urandom(), HANDLE_W'($urandom()));
            n = $urandom_range(4, DEPTH + 3);
            repeat (n)
                send_word($urandom_range(0, 1) ? OP_POP : OP_PEEK, key, $urandom(),
                          HANDLE_W'($urandom()));
            if ($urandom_range(0, 2) == 0)
                send_word(OP_QUERY, key, $urandom(), HANDLE_W'($urandom()));
            if ($urandom_range(0, 3) == 0)
                send_word(pick_op(), pick_key(), $urandom(), HANDLE_W'($urandom()));
        end
    endtask

    initial
    begin
        int idx;
        logic [KEY_W-1:0] cand;
        bit fresh;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        opcode       <= OP_ADD;
        key_id       <= '0;
        entry_number <= '0;
        entry_handle <= '0;
        mismatches        = 0;
        words_sent        = 0;
        responses_checked = 0;
        idle_on           = 1'b1;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_id[i]   = '0;
            q_head[i]    = '0;
            q_len[i]     = '0;
        end
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        idx = 2;
        while (idx < POOL_SIZE)
        begin
            cand  = KEY_W'($urandom());
            fresh = 1'b1;
            for (int j = 0; j < idx; j++)
                if (key_pool[j] == cand)
                    fresh = 1'b0;
            if (fresh)
            begin
                key_pool[idx] = cand;
                idx++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random_mix(800);
        test_fill_drain(25);
        idle_on = 1'b0;
        test_random_mix(150);
        test_fill_drain(5);

        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("Covered %0d words over all opcodes incl. unused codes; %0d results checked",
                 words_sent, responses_checked);
        $display("Outcomes: ok %0d, no key %0d, dup key %0d, empty %0d, table full %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_EXISTS],
                 status_seen[ST_EMPTY], status_seen[ST_TABLE_FULL], "queue full",
                 status_seen[ST_QUEUE_FULL]);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
